// ===== rtl/tqd_pkg.sv =====
package tqd_pkg;

    // fixed field widths
    localparam int CoordWidth   = 16;
    localparam int CountWidth   = 32;
    localparam int QualityWidth = 17;
    localparam int TotalWidth   = 32;

    localparam logic [QualityWidth-1:0] ThresholdReset = QualityWidth'(6554);
    localparam logic [QualityWidth-1:0] QualityMax     = QualityWidth'(65536);

    // datapath widths
    localparam int DiffWidth   = CoordWidth + 1;
    localparam int OpWidth     = CoordWidth + 2;
    localparam int ProdWidth   = 2 * OpWidth;
    localparam int KWidth      = 2 * CoordWidth + 3;
    localparam int KMagWidth   = KWidth - 1;
    localparam int HalfWidth   = KMagWidth / 2;
    localparam int SumWidth    = 2 * CoordWidth + 4;
    localparam int C2Width     = 4 * CoordWidth + 4;
    localparam int MWidth      = C2Width + 4;
    localparam int FracShift   = 32;
    localparam int RadWidth    = MWidth + FracShift;
    localparam int RootWidth   = RadWidth / 2;
    localparam int RemWidth    = RootWidth + 2;
    localparam int MacSteps    = 24;
    localparam int MacIdxWidth = $clog2(MacSteps);
    localparam int StepWidth   = $clog2(RootWidth + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_PREP,
        ST_ROOT,
        ST_DIV,
        ST_DONE
    } tqd_state_t;

    typedef enum logic [3:0] {
        SRC_UX, SRC_UY, SRC_UZ,
        SRC_VX, SRC_VY, SRC_VZ,
        SRC_WX, SRC_WY, SRC_WZ,
        SRC_KX_LO, SRC_KX_HI,
        SRC_KY_LO, SRC_KY_HI,
        SRC_KZ_LO, SRC_KZ_HI
    } tqd_src_t;

    typedef enum logic [2:0] {
        DST_KX,
        DST_KY,
        DST_KZ,
        DST_SUM,
        DST_C2
    } tqd_dst_t;

    typedef enum logic [1:0] {
        SH_LOW,
        SH_MID,
        SH_HIGH
    } tqd_shift_t;

    typedef struct packed {
        tqd_src_t   src_a;
        tqd_src_t   src_b;
        tqd_dst_t   dst;
        logic       neg;
        tqd_shift_t shift;
    } tqd_mac_op_t;

    // multiply-accumulate program: cross product, squared edge lengths,
    // then |k|^2 from two half-width pieces per component
    localparam tqd_mac_op_t MacOps [MacSteps] = '{
        '{SRC_UY,    SRC_VZ,    DST_KX,  1'b0, SH_LOW},
        '{SRC_UZ,    SRC_VY,    DST_KX,  1'b1, SH_LOW},
        '{SRC_UZ,    SRC_VX,    DST_KY,  1'b0, SH_LOW},
        '{SRC_UX,    SRC_VZ,    DST_KY,  1'b1, SH_LOW},
        '{SRC_UX,    SRC_VY,    DST_KZ,  1'b0, SH_LOW},
        '{SRC_UY,    SRC_VX,    DST_KZ,  1'b1, SH_LOW},
        '{SRC_UX,    SRC_UX,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_UY,    SRC_UY,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_UZ,    SRC_UZ,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_VX,    SRC_VX,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_VY,    SRC_VY,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_VZ,    SRC_VZ,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_WX,    SRC_WX,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_WY,    SRC_WY,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_WZ,    SRC_WZ,    DST_SUM, 1'b0, SH_LOW},
        '{SRC_KX_LO, SRC_KX_LO, DST_C2,  1'b0, SH_LOW},
        '{SRC_KX_HI, SRC_KX_LO, DST_C2,  1'b0, SH_MID},
        '{SRC_KX_HI, SRC_KX_HI, DST_C2,  1'b0, SH_HIGH},
        '{SRC_KY_LO, SRC_KY_LO, DST_C2,  1'b0, SH_LOW},
        '{SRC_KY_HI, SRC_KY_LO, DST_C2,  1'b0, SH_MID},
        '{SRC_KY_HI, SRC_KY_HI, DST_C2,  1'b0, SH_HIGH},
        '{SRC_KZ_LO, SRC_KZ_LO, DST_C2,  1'b0, SH_LOW},
        '{SRC_KZ_HI, SRC_KZ_LO, DST_C2,  1'b0, SH_MID},
        '{SRC_KZ_HI, SRC_KZ_HI, DST_C2,  1'b0, SH_HIGH}
    };

    typedef struct packed {
        logic                   load;
        logic                   mul_en;
        logic [MacIdxWidth-1:0] mul_step;
        logic                   prep;
        logic                   root_en;
        logic                   div_load;
        logic                   div_en;
        logic                   finish;
    } tqd_ctrl_t;

    typedef struct packed {
        logic signed [CoordWidth-1:0] a_x;
        logic signed [CoordWidth-1:0] a_y;
        logic signed [CoordWidth-1:0] a_z;
        logic signed [CoordWidth-1:0] b_x;
        logic signed [CoordWidth-1:0] b_y;
        logic signed [CoordWidth-1:0] b_z;
        logic signed [CoordWidth-1:0] c_x;
        logic signed [CoordWidth-1:0] c_y;
        logic signed [CoordWidth-1:0] c_z;
        logic                         last_triangle;
    } tqd_in_t;

    typedef struct packed {
        logic [QualityWidth-1:0] quality;
        logic                    is_degenerate;
        logic [TotalWidth-1:0]   degenerate_total;
        logic                    mesh_done;
        logic                    mesh_has_degenerate;
    } tqd_out_t;

endpackage

// ===== rtl/tqd_mul.sv =====
module tqd_mul
    import tqd_pkg::*;
#(
    parameter int OP_WIDTH  = OpWidth,
    parameter int TAG_WIDTH = MacIdxWidth
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [TAG_WIDTH-1:0]         tag,
    input  logic signed [OP_WIDTH-1:0]   op_a,
    input  logic signed [OP_WIDTH-1:0]   op_b,
    output logic signed [2*OP_WIDTH-1:0] prod,
    output logic [TAG_WIDTH-1:0]         prod_tag,
    output logic                         prod_vld
);

    logic signed [2*OP_WIDTH-1:0] prod_reg;
    logic signed [2*OP_WIDTH-1:0] prod_next;
    logic [TAG_WIDTH-1:0]         tag_reg;
    logic                         vld_reg;

    assign prod_next = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            tag_reg  <= tag;
        end
    end

    assign prod     = prod_reg;
    assign prod_tag = tag_reg;
    assign prod_vld = vld_reg;

endmodule

// ===== rtl/tqd_cmpsub.sv =====
module tqd_cmpsub
    import tqd_pkg::*;
#(
    parameter int WIDTH = RemWidth
)
(
    input  logic [WIDTH-1:0] op_a,
    input  logic [WIDTH-1:0] op_b,
    output logic             ge,
    output logic [WIDTH-1:0] diff
);

    logic borrow;

    // one subtract gives both the compare and the difference
    assign {borrow, diff} = {1'b0, op_a} - {1'b0, op_b};
    assign ge = ~borrow;

endmodule

// ===== rtl/tqd_seq.sv =====
module tqd_seq
    import tqd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_free,
    output logic      in_ready,
    output tqd_ctrl_t ctrl
);

    localparam logic [StepWidth-1:0] MacLast  = StepWidth'(MacSteps);
    localparam logic [StepWidth-1:0] RootLast = StepWidth'(RootWidth - 1);
    localparam logic [StepWidth-1:0] DivLast  = StepWidth'(QualityWidth);

    tqd_state_t           state_reg;
    tqd_state_t           state_next;
    logic [StepWidth-1:0] step_reg;
    logic [StepWidth-1:0] step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg + StepWidth'(1);
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_valid)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (step_reg == MacLast)
                begin
                    state_next = ST_PREP;
                    step_next  = '0;
                end
            end
            ST_PREP:
            begin
                state_next = ST_ROOT;
                step_next  = '0;
            end
            ST_ROOT:
            begin
                if (step_reg == RootLast)
                begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV:
            begin
                if (step_reg == DivLast)
                begin
                    state_next = ST_DONE;
                    step_next  = '0;
                end
            end
            ST_DONE:
            begin
                step_next = '0;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl          = '0;
        ctrl.mul_step = step_reg[MacIdxWidth-1:0];
        in_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            ST_MAC:
            begin
                ctrl.mul_en = (step_reg < MacLast);
            end
            ST_PREP:
            begin
                ctrl.prep = 1'b1;
            end
            ST_ROOT:
            begin
                ctrl.root_en = 1'b1;
            end
            ST_DIV:
            begin
                ctrl.div_load = (step_reg == '0);
                ctrl.div_en   = (step_reg != '0);
            end
            ST_DONE:
            begin
                ctrl.finish = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/triangle_quality_degenerate_counter.sv =====
// triangle shape quality with a degenerate-triangle counter
//
// in channel: in_valid/in_ready carry one triangle request (nine signed
// vertex coordinates plus last_triangle). out channel: out_valid/out_ready
// carry one result per request: Q1.16 quality, the degenerate flag, the
// running mesh count and, on the last triangle, whether the mesh held any
// degenerate triangle. cfg channel: cfg_valid/cfg_ready write the quality
// threshold, always ready; user must write only while idle, not enforced.
//
// a new request is taken only in the idle state, after the previous result
// has gone to the output register. 24 passes through one 18x18 multiplier
// build the cross product, the squared edge sum and |k|^2, then the
// 52-step square root and the 17-step division both run on one shared
// compare-subtract unit.
//
// reset clears the sequencer, the count and the output valid, and loads the
// threshold with its default of 6554. when the receiver stalls, the result
// waits in the output register while the next request is already taken and
// worked on; that one then waits in its final state until the register frees.
module triangle_quality_degenerate_counter
    import tqd_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidth
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  tqd_in_t                 in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output tqd_out_t                out_data,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [QualityWidth-1:0] cfg_quality_threshold
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    tqd_ctrl_t ctrl;
    logic      out_free;

    // edge vectors u = B-A, v = C-A, w = C-B
    logic signed [DiffWidth-1:0] ux_reg, uy_reg, uz_reg;
    logic signed [DiffWidth-1:0] vx_reg, vy_reg, vz_reg;
    logic signed [DiffWidth-1:0] wx_reg, wy_reg, wz_reg;
    logic                        last_reg;

    // accumulators
    logic signed [KWidth-1:0] kx_reg, ky_reg, kz_reg;
    logic signed [KWidth-1:0] kx_next, ky_next, kz_next;
    logic [SumWidth-1:0]      sum_reg, sum_next;
    logic [C2Width-1:0]       c2_reg, c2_next;

    // root and divide state
    logic [RadWidth-1:0]     rad_reg, rad_next;
    logic [RootWidth-1:0]    root_reg, root_next;
    logic [RemWidth-1:0]     rem_reg, rem_next;
    logic [QualityWidth-1:0] qbits_reg, qbits_next;
    logic                    c2_zero_reg, c2_zero_next;

    // config, count and output
    logic [QualityWidth-1:0] threshold_reg;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [COUNT_WIDTH-1:0]  count_upd;
    tqd_out_t                out_reg, out_next;
    logic                    out_valid_reg;

    // shared units
    logic signed [OpWidth-1:0]   mul_a, mul_b;
    logic signed [ProdWidth-1:0] prod;
    logic [MacIdxWidth-1:0]      prod_tag;
    logic                        prod_vld;
    tqd_mac_op_t                 issue_op, acc_op;

    logic [RemWidth-1:0] cs_a, cs_b, cs_diff;
    logic                cs_ge;

    logic [KMagWidth-1:0] kx_mag, ky_mag, kz_mag;
    logic [RemWidth-1:0]  x_root, trial_root, x_div, d_div;
    logic [MWidth-1:0]    m_val;
    logic [QualityWidth-1:0] quality_val;
    logic                    degen;

    assign out_free = !out_valid_reg || out_ready;

    tqd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .out_free (out_free),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // |k| split into a low and a high half for the squaring passes
    assign kx_mag = kx_reg[KWidth-1] ? KMagWidth'(-kx_reg) : kx_reg[KMagWidth-1:0];
    assign ky_mag = ky_reg[KWidth-1] ? KMagWidth'(-ky_reg) : ky_reg[KMagWidth-1:0];
    assign kz_mag = kz_reg[KWidth-1] ? KMagWidth'(-kz_reg) : kz_reg[KMagWidth-1:0];

    assign issue_op = MacOps[ctrl.mul_step];
    assign acc_op   = MacOps[prod_tag];

    // operand select for the multiplier, edge terms sign-extended, k halves
    // zero-extended
    always_comb
    begin
        case (issue_op.src_a)
            SRC_UX:    mul_a = {ux_reg[DiffWidth-1], ux_reg};
            SRC_UY:    mul_a = {uy_reg[DiffWidth-1], uy_reg};
            SRC_UZ:    mul_a = {uz_reg[DiffWidth-1], uz_reg};
            SRC_VX:    mul_a = {vx_reg[DiffWidth-1], vx_reg};
            SRC_VY:    mul_a = {vy_reg[DiffWidth-1], vy_reg};
            SRC_VZ:    mul_a = {vz_reg[DiffWidth-1], vz_reg};
            SRC_WX:    mul_a = {wx_reg[DiffWidth-1], wx_reg};
            SRC_WY:    mul_a = {wy_reg[DiffWidth-1], wy_reg};
            SRC_WZ:    mul_a = {wz_reg[DiffWidth-1], wz_reg};
            SRC_KX_LO: mul_a = {1'b0, kx_mag[HalfWidth-1:0]};
            SRC_KX_HI: mul_a = {1'b0, kx_mag[KMagWidth-1:HalfWidth]};
            SRC_KY_LO: mul_a = {1'b0, ky_mag[HalfWidth-1:0]};
            SRC_KY_HI: mul_a = {1'b0, ky_mag[KMagWidth-1:HalfWidth]};
            SRC_KZ_LO: mul_a = {1'b0, kz_mag[HalfWidth-1:0]};
            SRC_KZ_HI: mul_a = {1'b0, kz_mag[KMagWidth-1:HalfWidth]};
            default:   mul_a = '0;
        endcase
    end

    always_comb
    begin
        case (issue_op.src_b)
            SRC_UX:    mul_b = {ux_reg[DiffWidth-1], ux_reg};
            SRC_UY:    mul_b = {uy_reg[DiffWidth-1], uy_reg};
            SRC_UZ:    mul_b = {uz_reg[DiffWidth-1], uz_reg};
            SRC_VX:    mul_b = {vx_reg[DiffWidth-1], vx_reg};
            SRC_VY:    mul_b = {vy_reg[DiffWidth-1], vy_reg};
            SRC_VZ:    mul_b = {vz_reg[DiffWidth-1], vz_reg};
            SRC_WX:    mul_b = {wx_reg[DiffWidth-1], wx_reg};
            SRC_WY:    mul_b = {wy_reg[DiffWidth-1], wy_reg};
            SRC_WZ:    mul_b = {wz_reg[DiffWidth-1], wz_reg};
            SRC_KX_LO: mul_b = {1'b0, kx_mag[HalfWidth-1:0]};
            SRC_KX_HI: mul_b = {1'b0, kx_mag[KMagWidth-1:HalfWidth]};
            SRC_KY_LO: mul_b = {1'b0, ky_mag[HalfWidth-1:0]};
            SRC_KY_HI: mul_b = {1'b0, ky_mag[KMagWidth-1:HalfWidth]};
            SRC_KZ_LO: mul_b = {1'b0, kz_mag[HalfWidth-1:0]};
            SRC_KZ_HI: mul_b = {1'b0, kz_mag[KMagWidth-1:HalfWidth]};
            default:   mul_b = '0;
        endcase
    end

    tqd_mul #(
        .OP_WIDTH  (OpWidth),
        .TAG_WIDTH (MacIdxWidth)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (ctrl.mul_en),
        .tag      (ctrl.mul_step),
        .op_a     (mul_a),
        .op_b     (mul_b),
        .prod     (prod),
        .prod_tag (prod_tag),
        .prod_vld (prod_vld)
    );

    // accumulate the registered product in the cycle after it was issued
    always_comb
    begin
        kx_next  = kx_reg;
        ky_next  = ky_reg;
        kz_next  = kz_reg;
        sum_next = sum_reg;
        c2_next  = c2_reg;
        if (ctrl.load)
        begin
            kx_next  = '0;
            ky_next  = '0;
            kz_next  = '0;
            sum_next = '0;
            c2_next  = '0;
        end
        else if (prod_vld)
        begin
            case (acc_op.dst)
                DST_KX:
                    kx_next = acc_op.neg ? kx_reg - prod[KWidth-1:0]
                                         : kx_reg + prod[KWidth-1:0];
                DST_KY:
                    ky_next = acc_op.neg ? ky_reg - prod[KWidth-1:0]
                                         : ky_reg + prod[KWidth-1:0];
                DST_KZ:
                    kz_next = acc_op.neg ? kz_reg - prod[KWidth-1:0]
                                         : kz_reg + prod[KWidth-1:0];
                DST_SUM:
                    sum_next = sum_reg + SumWidth'(prod);
                DST_C2:
                begin
                    case (acc_op.shift)
                        SH_MID:
                            c2_next = c2_reg
                                + ({{(C2Width-ProdWidth){1'b0}}, prod} << (HalfWidth + 1));
                        SH_HIGH:
                            c2_next = c2_reg
                                + ({{(C2Width-ProdWidth){1'b0}}, prod} << (2 * HalfWidth));
                        default:
                            c2_next = c2_reg + {{(C2Width-ProdWidth){1'b0}}, prod};
                    endcase
                end
                default:
                begin
                    c2_next = c2_reg;
                end
            endcase
        end
    end

    // 12 * C2, then scaled by 2^32 into the radicand
    assign m_val = {1'b0, c2_reg, 3'b000} + {2'b00, c2_reg, 2'b00};

    // shared compare-subtract: root trial or divisor
    assign x_root     = {rem_reg[RootWidth-1:0], rad_reg[RadWidth-1 -: 2]};
    assign trial_root = {root_reg, 2'b01};
    assign x_div      = {rem_reg[RootWidth:0], qbits_reg[QualityWidth-1]};
    assign d_div      = {{(RemWidth-SumWidth){1'b0}}, sum_reg};

    assign cs_a = ctrl.root_en ? x_root : x_div;
    assign cs_b = ctrl.root_en ? trial_root : d_div;

    tqd_cmpsub #(
        .WIDTH (RemWidth)
    ) u_cmpsub (
        .op_a (cs_a),
        .op_b (cs_b),
        .ge   (cs_ge),
        .diff (cs_diff)
    );

    always_comb
    begin
        rad_next     = rad_reg;
        root_next    = root_reg;
        rem_next     = rem_reg;
        qbits_next   = qbits_reg;
        c2_zero_next = c2_zero_reg;
        if (ctrl.prep)
        begin
            rad_next     = {m_val, {FracShift{1'b0}}};
            root_next    = '0;
            rem_next     = '0;
            c2_zero_next = (c2_reg == '0);
        end
        else if (ctrl.root_en)
        begin
            rad_next  = {rad_reg[RadWidth-3:0], 2'b00};
            rem_next  = cs_ge ? cs_diff : x_root;
            root_next = {root_reg[RootWidth-2:0], cs_ge};
        end
        else if (ctrl.div_load)
        begin
            // root < sum * 2^17, so the upper part is already below the divisor
            rem_next   = {{(RemWidth-RootWidth+QualityWidth){1'b0}},
                          root_reg[RootWidth-1:QualityWidth]};
            qbits_next = root_reg[QualityWidth-1:0];
        end
        else if (ctrl.div_en)
        begin
            rem_next   = cs_ge ? cs_diff : x_div;
            qbits_next = {qbits_reg[QualityWidth-2:0], cs_ge};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ux_reg   <= {in_data.b_x[CoordWidth-1], in_data.b_x}
                      - {in_data.a_x[CoordWidth-1], in_data.a_x};
            uy_reg   <= {in_data.b_y[CoordWidth-1], in_data.b_y}
                      - {in_data.a_y[CoordWidth-1], in_data.a_y};
            uz_reg   <= {in_data.b_z[CoordWidth-1], in_data.b_z}
                      - {in_data.a_z[CoordWidth-1], in_data.a_z};
            vx_reg   <= {in_data.c_x[CoordWidth-1], in_data.c_x}
                      - {in_data.a_x[CoordWidth-1], in_data.a_x};
            vy_reg   <= {in_data.c_y[CoordWidth-1], in_data.c_y}
                      - {in_data.a_y[CoordWidth-1], in_data.a_y};
            vz_reg   <= {in_data.c_z[CoordWidth-1], in_data.c_z}
                      - {in_data.a_z[CoordWidth-1], in_data.a_z};
            wx_reg   <= {in_data.c_x[CoordWidth-1], in_data.c_x}
                      - {in_data.b_x[CoordWidth-1], in_data.b_x};
            wy_reg   <= {in_data.c_y[CoordWidth-1], in_data.c_y}
                      - {in_data.b_y[CoordWidth-1], in_data.b_y};
            wz_reg   <= {in_data.c_z[CoordWidth-1], in_data.c_z}
                      - {in_data.b_z[CoordWidth-1], in_data.b_z};
            last_reg <= in_data.last_triangle;
        end
        kx_reg      <= kx_next;
        ky_reg      <= ky_next;
        kz_reg      <= kz_next;
        sum_reg     <= sum_next;
        c2_reg      <= c2_next;
        rad_reg     <= rad_next;
        root_reg    <= root_next;
        rem_reg     <= rem_next;
        qbits_reg   <= qbits_next;
        c2_zero_reg <= c2_zero_next;
        out_reg     <= out_next;
    end

    // result: collinear or coincident vertices give zero quality
    assign quality_val = c2_zero_reg ? '0
                       : ((qbits_reg > QualityMax) ? QualityMax : qbits_reg);
    assign degen     = (quality_val < threshold_reg);
    assign count_upd = (degen && (count_reg != CountMax))
                     ? count_reg + COUNT_WIDTH'(1) : count_reg;

    always_comb
    begin
        out_next   = out_reg;
        count_next = count_reg;
        if (ctrl.finish)
        begin
            out_next.quality             = quality_val;
            out_next.is_degenerate       = degen;
            out_next.degenerate_total    = TotalWidth'(count_upd);
            out_next.mesh_done           = last_reg;
            out_next.mesh_has_degenerate = last_reg && (count_upd != '0);
            count_next                   = last_reg ? '0 : count_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= ThresholdReset;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                threshold_reg <= cfg_quality_threshold;
            end
            count_reg <= count_next;
            if (ctrl.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
